// ===== sv/gad_pkg.sv =====
// shared types, constants and hat decode for the gamepad autorepeat decoder
`timescale 1ns / 1ps

package gad_pkg;

  // field widths
  localparam int unsigned TimeW    = 20;
  localparam int unsigned TimerW   = 21;
  localparam int unsigned AngleW   = 16;
  localparam int unsigned ButtonW  = 12;
  localparam int unsigned AxisW    = 11;
  localparam int unsigned DeadHiW  = 10;
  localparam int unsigned BitsW    = 16;
  localparam int unsigned HatW     = 4;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned NumButtonsDefault = 12;

  // stream word layouts
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 96;

  // register reset values
  localparam logic [TimeW-1:0]   FirstDelayRst  = TimeW'(250000);
  localparam logic [TimeW-1:0]   RepeatIntRst   = TimeW'(33000);
  localparam logic [AxisW-1:0]   DeadLowRst     = AxisW'(-200);
  localparam logic [DeadHiW-1:0] DeadHighRst    = DeadHiW'(200);

  localparam logic [TimerW-1:0]  TimerMax       = {TimerW{1'b1}};

  // hat direction bits
  localparam logic [HatW-1:0] HatUp    = 4'b0001;
  localparam logic [HatW-1:0] HatRight = 4'b0010;
  localparam logic [HatW-1:0] HatDown  = 4'b0100;
  localparam logic [HatW-1:0] HatLeft  = 4'b1000;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_DELAY = 2'd0,
    CFG_REPEAT_INT  = 2'd1,
    CFG_DEAD_LOW    = 2'd2,
    CFG_DEAD_HIGH   = 2'd3
  } cfg_idx_e;

  // per-bit repeat phase
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_FIRST    = 2'd1,
    PH_REPEAT   = 2'd2
  } phase_e;

  // timing configuration shared by all repeat cells
  typedef struct packed {
    logic [TimeW-1:0] first_delay;
    logic [TimeW-1:0] repeat_int;
  } rpt_cfg_t;

  // eight 45 degree sectors, anything at or past the last edge is up
  function automatic logic [HatW-1:0] hat_decode(input logic [AngleW-1:0] a);
    logic [HatW-1:0] r;
    if (a < AngleW'(2250) || a >= AngleW'(33750)) r = HatUp;
    else if (a < AngleW'(6750))  r = HatUp | HatRight;
    else if (a < AngleW'(11250)) r = HatRight;
    else if (a < AngleW'(15750)) r = HatDown | HatRight;
    else if (a < AngleW'(20250)) r = HatDown;
    else if (a < AngleW'(24750)) r = HatDown | HatLeft;
    else if (a < AngleW'(29250)) r = HatLeft;
    else r = HatUp | HatLeft;
    return r;
  endfunction

endpackage

// ===== sv/gad_repeat_cell.sv =====
// typematic repeat cell for one pressed bit
`timescale 1ns / 1ps

module gad_repeat_cell
  import gad_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             pressed_i,
  input  logic [TimeW-1:0] elapsed_i,
  input  rpt_cfg_t         cfg_i,
  output logic             fire_o
);

  phase_e              phase_q, phase_d;
  logic [TimerW-1:0]   timer_q, timer_d;
  logic [TimerW:0]     sum;
  logic [TimerW-1:0]   sat;
  logic [TimeW-1:0]    gap;

  // saturating hold time and current gap
  always_comb begin
    sum = {1'b0, timer_q} + (TimerW+1)'(elapsed_i);
    sat = sum[TimerW] ? TimerMax : sum[TimerW-1:0];
    gap = (phase_q == PH_FIRST) ? cfg_i.first_delay : cfg_i.repeat_int;
  end

  // next phase, timer and fire
  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    fire_o  = 1'b0;
    if (!pressed_i) begin
      phase_d = PH_RELEASED;
    end else begin
      unique case (phase_q)
        PH_RELEASED: begin
          fire_o  = 1'b1;
          timer_d = '0;
          phase_d = PH_FIRST;
        end
        default: begin
          if (sat > TimerW'(gap)) begin
            fire_o  = 1'b1;
            timer_d = '0;
            phase_d = PH_REPEAT;
          end else begin
            timer_d = sat;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RELEASED;
      timer_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

endmodule

// ===== sv/gad_dead_zone.sv =====
// axis dead zone removal
`timescale 1ns / 1ps

module gad_dead_zone
  import gad_pkg::*;
(
  input  logic [AxisW-1:0]   raw_i,
  input  logic [AxisW-1:0]   dead_low_i,
  input  logic [DeadHiW-1:0] dead_high_i,
  output logic [AxisW-1:0]   axis_o
);

  logic signed [AxisW:0] v, lo, hi;
  logic                  in_zone;

  // compare at one extra bit so the unsigned upper bound stays positive
  always_comb begin
    v       = $signed({raw_i[AxisW-1], raw_i});
    lo      = $signed({dead_low_i[AxisW-1], dead_low_i});
    hi      = $signed({2'b00, dead_high_i});
    in_zone = (lo <= v) && (v <= hi);
    axis_o  = in_zone ? '0 : raw_i;
  end

endmodule

// ===== sv/gamepad_autorepeat_decoder_core.sv =====
// top level: input register, hat and button decode, repeat cells, result register
`timescale 1ns / 1ps

// One poll in, one result out. A poll is taken into an input register, decoded
// combinationally (hat sectors, button mask, dead zone on four axes, sixteen
// repeat cells in parallel) and written into the result register; a new poll is
// accepted every cycle while the result side keeps up. The throughput limit is
// the update of the per-bit hold timers, which holds each cell's state from one
// poll to the next. Config writes are taken at any time with cfg_ready_o always
// high and apply to polls that leave the input register after the write.
module gamepad_autorepeat_decoder_core
  import gad_pkg::*;
#(
  parameter int unsigned NUM_BUTTONS = NumButtonsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input word
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pov_angle[15:0], button_bits[27:16], axis_x_raw[38:28], axis_y_raw[49:39],
  // axis_rx_raw[60:50], axis_ry_raw[71:61], elapsed_us[91:72], zero[95:92]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // pov_centered[0]
  input  logic                s_axis_tuser,
  // result word
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // press_bits[15:0], stroke_bits[31:16], repeat_bits[47:32], axis_x[58:48],
  // axis_y[69:59], axis_u[80:70], axis_v[91:81], zero[95:92]
  output logic [OutDataW-1:0] m_axis_tdata,
  // configuration write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  // configuration registers
  rpt_cfg_t             rcfg_q;
  logic [AxisW-1:0]     dead_low_q;
  logic [DeadHiW-1:0]   dead_high_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcfg_q.first_delay <= FirstDelayRst;
      rcfg_q.repeat_int  <= RepeatIntRst;
      dead_low_q         <= DeadLowRst;
      dead_high_q        <= DeadHighRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FIRST_DELAY: rcfg_q.first_delay <= cfg_data_i;
        CFG_REPEAT_INT:  rcfg_q.repeat_int  <= cfg_data_i;
        CFG_DEAD_LOW:    dead_low_q         <= cfg_data_i[AxisW-1:0];
        CFG_DEAD_HIGH:   dead_high_q        <= cfg_data_i[DeadHiW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_valid_q;
  logic [InDataW-1:0]   in_data_q;
  logic                 in_cent_q;
  logic                 step;

  assign step          = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
      in_cent_q <= s_axis_tuser;
    end
  end

  // unpack the held word
  logic [AngleW-1:0]  angle;
  logic [ButtonW-1:0] buttons;
  logic [AxisW-1:0]   ax_x, ax_y, ax_rx, ax_ry;
  logic [TimeW-1:0]   elapsed;

  assign angle   = in_data_q[15:0];
  assign buttons = in_data_q[27:16];
  assign ax_x    = in_data_q[38:28];
  assign ax_y    = in_data_q[49:39];
  assign ax_rx   = in_data_q[60:50];
  assign ax_ry   = in_data_q[71:61];
  assign elapsed = in_data_q[91:72];

  // button mask from the configured count
  logic [ButtonW-1:0] bmask;
  for (genvar b = 0; b < ButtonW; b++) begin : g_mask
    assign bmask[b] = (b < NUM_BUTTONS);
  end

  // pressed bits of this poll
  logic [BitsW-1:0] now_bits;
  logic [HatW-1:0]  hat;

  always_comb begin
    hat      = in_cent_q ? '0 : hat_decode(angle);
    now_bits = {buttons & bmask, hat};
  end

  // per-bit repeat cells
  logic [BitsW-1:0] fire;
  for (genvar i = 0; i < BitsW; i++) begin : g_cell
    gad_repeat_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .step_i    (step),
      .pressed_i (now_bits[i]),
      .elapsed_i (elapsed),
      .cfg_i     (rcfg_q),
      .fire_o    (fire[i])
    );
  end

  // dead zone on each axis
  logic [AxisW-1:0] dz_x, dz_y, dz_u, dz_v;

  gad_dead_zone u_dz_x (
    .raw_i(ax_x), .dead_low_i(dead_low_q), .dead_high_i(dead_high_q), .axis_o(dz_x)
  );
  gad_dead_zone u_dz_y (
    .raw_i(ax_y), .dead_low_i(dead_low_q), .dead_high_i(dead_high_q), .axis_o(dz_y)
  );
  gad_dead_zone u_dz_u (
    .raw_i(ax_ry), .dead_low_i(dead_low_q), .dead_high_i(dead_high_q), .axis_o(dz_u)
  );
  gad_dead_zone u_dz_v (
    .raw_i(ax_rx), .dead_low_i(dead_low_q), .dead_high_i(dead_high_q), .axis_o(dz_v)
  );

  // previous poll's pressed bits
  logic [BitsW-1:0] held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (step) begin
      held_q <= now_bits;
    end
  end

  // result register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {4'b0000, dz_v, dz_u, dz_y, dz_x, fire, now_bits & ~held_q, now_bits};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sim/gamepad_autorepeat_decoder_core_test.sv =====
// self-checking testbench for the gamepad autorepeat decoder: directed and random polls
`timescale 1ns / 1ps

module gamepad_autorepeat_decoder_core_test;
  import gad_pkg::*;

  // one poll; everything below centered packs into tdata, lowest field last
  typedef struct packed {
    logic                    centered;
    logic [TimeW-1:0]        elapsed;
    logic signed [AxisW-1:0] ary;
    logic signed [AxisW-1:0] arx;
    logic signed [AxisW-1:0] ay;
    logic signed [AxisW-1:0] ax;
    logic [ButtonW-1:0]      buttons;
    logic [AngleW-1:0]       angle;
  } poll_t;

  // one result word, lowest field last
  typedef struct packed {
    logic signed [AxisW-1:0] v;
    logic signed [AxisW-1:0] u;
    logic signed [AxisW-1:0] y;
    logic signed [AxisW-1:0] x;
    logic [BitsW-1:0]        fired;
    logic [BitsW-1:0]        stroke;
    logic [BitsW-1:0]        press;
  } result_t;

  localparam int PollDataW = $bits(poll_t) - 1;
  localparam int MaxReports = 100;

  // predicts each result word from the accepted polls and checks the outputs
  class autorepeat_scoreboard;
    logic [TimeW-1:0]  first_delay;
    logic [TimeW-1:0]  repeat_gap;
    int                dead_lo;
    int                dead_hi;
    logic [BitsW-1:0]  held;
    phase_e            hold_phase [BitsW];
    logic [TimerW-1:0] hold_us [BitsW];
    result_t           expected_results [$];
    int                errors;
    int                polls;
    int                results;
    int                repeat_results;
    int                stroke_results;

    function new();
      first_delay = FirstDelayRst;
      repeat_gap = RepeatIntRst;
      dead_lo = int'($signed(DeadLowRst));
      dead_hi = int'(DeadHighRst);
      held = '0;
      for (int i = 0; i < BitsW; i++) begin
        hold_phase[i] = PH_RELEASED;
        hold_us[i] = '0;
      end
      errors = 0;
      polls = 0;
      results = 0;
      repeat_results = 0;
      stroke_results = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [TimeW-1:0] data);
      case (idx)
        CFG_FIRST_DELAY: first_delay = data;
        CFG_REPEAT_INT:  repeat_gap = data;
        CFG_DEAD_LOW:    dead_lo = int'($signed(data[AxisW-1:0]));
        CFG_DEAD_HIGH:   dead_hi = int'(data[DeadHiW-1:0]);
        default: ;
      endcase
    endfunction

    // eight sectors centered on multiples of 45 degrees, wrap and overflow go up
    function logic [HatW-1:0] hat_dirs(logic [AngleW-1:0] a);
      int sector;
      sector = (a >= AngleW'(33750)) ? 0 : (int'(a) + 2250) / 4500;
      case (sector)
        0:       return HatUp;
        1:       return HatUp | HatRight;
        2:       return HatRight;
        3:       return HatDown | HatRight;
        4:       return HatDown;
        5:       return HatDown | HatLeft;
        6:       return HatLeft;
        default: return HatUp | HatLeft;
      endcase
    endfunction

    // inclusive zone; an inverted zone zeroes nothing
    function logic signed [AxisW-1:0] strip_dead(logic signed [AxisW-1:0] val);
      if (int'(val) >= dead_lo && int'(val) <= dead_hi) return '0;
      return val;
    endfunction

    function void note_poll(poll_t p);
      logic [BitsW-1:0]  now;
      logic [BitsW-1:0]  fire;
      logic [TimerW:0]   sum;
      logic [TimeW-1:0]  gap_us;
      result_t           r;
      now = '0;
      if (!p.centered) now[HatW-1:0] = hat_dirs(p.angle);
      now[BitsW-1:HatW] = p.buttons;
      fire = '0;
      // typematic cell per bit
      for (int i = 0; i < BitsW; i++) begin
        if (!now[i]) begin
          hold_phase[i] = PH_RELEASED;
        end else if (hold_phase[i] == PH_RELEASED) begin
          hold_us[i] = '0;
          fire[i] = 1'b1;
          hold_phase[i] = PH_FIRST;
        end else begin
          gap_us = (hold_phase[i] == PH_FIRST) ? first_delay : repeat_gap;
          sum = hold_us[i] + p.elapsed;
          if (sum > TimerMax) sum = TimerMax;
          if (sum > gap_us) begin
            fire[i] = 1'b1;
            hold_phase[i] = PH_REPEAT;
            hold_us[i] = '0;
          end else begin
            hold_us[i] = sum[TimerW-1:0];
          end
        end
      end
      r.press = now;
      r.stroke = now & ~held;
      r.fired = fire;
      r.x = strip_dead(p.ax);
      r.y = strip_dead(p.ay);
      r.u = strip_dead(p.ary);
      r.v = strip_dead(p.arx);
      held = now;
      expected_results.push_back(r);
      polls++;
    endfunction

    // reports stop after a while so a broken build cannot flood the log
    function void compare_field(string name, int want, int got);
      if (want != got) begin
        if (errors < MaxReports) $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OutDataW-1:0] word);
      result_t got;
      result_t want;
      got = word[$bits(result_t)-1:0];
      if (expected_results.size() == 0) begin
        if (errors < MaxReports) $error("result word %h with no poll waiting", word);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      results++;
      if (want.fired != '0) repeat_results++;
      if (want.stroke != '0) stroke_results++;
      compare_field("press_bits", want.press, got.press);
      compare_field("stroke_bits", want.stroke, got.stroke);
      compare_field("repeat_bits", want.fired, got.fired);
      compare_field("axis_x", want.x, got.x);
      compare_field("axis_y", want.y, got.y);
      compare_field("axis_u", want.u, got.u);
      compare_field("axis_v", want.v, got.v);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  cfg_idx_e            cfg_index_i = CFG_FIRST_DELAY;
  logic [TimeW-1:0]    cfg_data_i = '0;

  autorepeat_scoreboard sb = new();

  // poll generator state: buttons and hat stay held across polls
  logic [ButtonW-1:0] held_buttons = '0;
  logic               hat_off = 1'b1;
  logic [AngleW-1:0]  hat_angle = '0;
  int                 burst_left = 0;
  int                 rdy_mode = 0;
  int                 rdy_tick = 0;
  int                 cfg_writes = 0;

  gamepad_autorepeat_decoder_core u_dut (.*);

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side stall pattern, with a randomly chosen mode
  always @(negedge clk_i) begin
    if (rdy_tick % 97 == 0) rdy_mode = $urandom_range(0, 3);
    case (rdy_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rdy_tick % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) != 0);
    endcase
    rdy_tick++;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL gamepad_autorepeat_decoder_core");
    $finish;
  end

  // one poll word, then either carry on the burst or idle for a while
  task automatic send_poll(poll_t p);
    int gap_cycles;
    s_axis_tdata = InDataW'(p[PollDataW-1:0]);
    s_axis_tuser = p.centered;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_poll(p);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = {$urandom, $urandom, $urandom};
      s_axis_tuser = 1'($urandom_range(0, 1));
      gap_cycles = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (gap_cycles) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [TimeW-1:0] data);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // stop sending, wait for every result, then let the pipeline empty
  task automatic settle(int tail);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (tail) @(negedge clk_i);
  endtask

  // values around the dead zone edges and the raw extremes
  function automatic logic signed [AxisW-1:0] probe_axis(int k);
    case (k % 9)
      0:       return AxisW'(-1024);
      1:       return AxisW'(-1000);
      2:       return AxisW'(-201);
      3:       return AxisW'(-200);
      4:       return '0;
      5:       return AxisW'(200);
      6:       return AxisW'(201);
      7:       return AxisW'(1000);
      default: return AxisW'(1023);
    endcase
  endfunction

  function automatic logic signed [AxisW-1:0] pick_axis();
    case ($urandom_range(0, 4))
      0:       return AxisW'($urandom);
      1:       return AxisW'(sb.dead_lo + int'($urandom_range(0, 2)) - 1);
      2:       return AxisW'(sb.dead_hi + int'($urandom_range(0, 2)) - 1);
      default: return AxisW'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  // mostly held controls with small changes, elapsed times scaled to the gaps
  function automatic poll_t next_poll();
    poll_t p;
    int    k;
    if ($urandom_range(0, 3) == 0) held_buttons ^= ButtonW'(1) << $urandom_range(0, ButtonW-1);
    if ($urandom_range(0, 19) == 0) held_buttons = ButtonW'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      hat_off = ($urandom_range(0, 2) == 0);
      k = $urandom_range(1, 8);
      hat_angle = $urandom_range(0, 1) ? AngleW'($urandom) :
                  AngleW'(4500 * k - 2250 - int'($urandom_range(0, 1)));
    end
    p.centered = hat_off;
    p.angle = hat_angle;
    p.buttons = held_buttons;
    p.ax = pick_axis();
    p.ay = pick_axis();
    p.arx = pick_axis();
    p.ary = pick_axis();
    case ($urandom_range(0, 9))
      0:       p.elapsed = TimeW'($urandom);
      1:       p.elapsed = '0;
      2, 3:    p.elapsed = TimeW'($urandom_range(0, int'(sb.first_delay) / 2 + 4));
      default: p.elapsed = TimeW'($urandom_range(0, int'(sb.repeat_gap) / 2 + 4));
    endcase
    // occasional poll of pure noise
    if ($urandom_range(0, 24) == 0) p = $bits(poll_t)'({$urandom, $urandom, $urandom});
    return p;
  endfunction

  initial begin
    poll_t            p;
    logic [TimeW-1:0] f;
    logic [TimeW-1:0] g;
    int               dl;
    int               dh;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // hat sector edges, out-of-range angles, axis extremes, reset settings
    for (int k = 0; k < 20; k++) begin
      p = '0;
      p.centered = (k == 19);
      case (k)
        16:      p.angle = '0;
        17:      p.angle = AngleW'(35999);
        18:      p.angle = AngleW'(36000);
        19:      p.angle = '1;
        default: p.angle = AngleW'(2250 + 4500 * (k / 2) - (1 - k % 2));
      endcase
      p.buttons = (k % 4 == 2) ? '0 : (k % 4 == 3) ? ButtonW'(12'h5A5) : '1;
      p.ax = probe_axis(k);
      p.ay = probe_axis(k + 2);
      p.arx = probe_axis(k + 4);
      p.ary = probe_axis(k + 7);
      case (k % 5)
        0:       p.elapsed = '0;
        1:       p.elapsed = TimeW'(250000);
        2:       p.elapsed = TimeW'(250001);
        3:       p.elapsed = '1;
        default: p.elapsed = TimeW'(33000);
      endcase
      send_poll(p);
    end

    // first delay and repeat gap boundaries on one button
    settle(4);
    write_reg(CFG_FIRST_DELAY, TimeW'(100));
    write_reg(CFG_REPEAT_INT, '0);
    for (int k = 0; k < 7; k++) begin
      p = '0;
      p.centered = 1'b1;
      p.buttons = (k == 5) ? '0 : ButtonW'(1);
      case (k)
        0:       p.elapsed = TimeW'(5);
        1:       p.elapsed = TimeW'(100);
        2, 4, 5: p.elapsed = TimeW'(1);
        3:       p.elapsed = '0;
        default: p.elapsed = '1;
      endcase
      send_poll(p);
    end

    // random phases, each under its own settings
    held_buttons = ButtonW'($urandom);
    for (int ph = 0; ph < 8; ph++) begin
      settle(4);
      case (ph)
        0: begin
          f = '0; g = '0; dl = 0; dh = 0;
        end
        1: begin
          f = '1; g = '1; dl = -1024; dh = 1023;
        end
        2: begin
          f = TimeW'($urandom_range(0, 20000)); g = TimeW'($urandom_range(0, 5000));
          dl = 1023; dh = 0;
        end
        3: begin
          f = TimeW'(1000000); g = TimeW'(1000000); dl = -1000; dh = 1000;
        end
        default: begin
          f = TimeW'($urandom_range(0, 20000));
          g = TimeW'($urandom_range(0, 5000));
          dl = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2047)) - 1024 :
               -int'($urandom_range(0, 400));
          dh = $urandom_range(0, 400);
        end
      endcase
      write_reg(CFG_FIRST_DELAY, f);
      write_reg(CFG_REPEAT_INT, g);
      // spare upper bits of the dead zone writes carry noise
      write_reg(CFG_DEAD_LOW, {(TimeW-AxisW)'($urandom), AxisW'(dl)});
      write_reg(CFG_DEAD_HIGH, {(TimeW-DeadHiW)'($urandom), DeadHiW'(dh)});
      for (int n = 0; n < 130; n++) send_poll(next_poll());
    end

    settle(8);
    $display("covered %0d polls under %0d register writes, %0d result words checked",
             sb.polls, cfg_writes, sb.results);
    $display("%0d words carried repeat events and %0d carried new presses",
             sb.repeat_results, sb.stroke_results);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS gamepad_autorepeat_decoder_core");
    end else begin
      $display("FAIL gamepad_autorepeat_decoder_core");
    end
    $finish;
  end

endmodule
